// ----- sv/csx_pkg.sv -----
// package: parse state, result codes and key name table for the cookie session id extractor
`default_nettype none
package csx_pkg;

   localparam int unsigned KEY_LENGTH = 10;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_EQ    = 8'h3d;
   localparam logic [7:0] CHAR_SEMI  = 8'h3b;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef enum logic [1:0] {
      KIND_NONE   = 2'd0,
      KIND_BYTE   = 2'd1,
      KIND_COMMIT = 2'd2,
      KIND_BAD    = 2'd3
   } kind_type;

   typedef struct packed {
      logic       in_key;
      logic       key_matched;
      logic       key_leading;
      logic       value_leading;
      logic [3:0] key_length;
      logic       prefix_ok;
      logic       halted;
   } parse_state_type;

   localparam parse_state_type NEW_PAIR = '{
      in_key:        1'b1,
      key_matched:   1'b0,
      key_leading:   1'b1,
      value_leading: 1'b0,
      key_length:    4'd0,
      prefix_ok:     1'b1,
      halted:        1'b0
   };

   localparam parse_state_type STATE_RESET = '{
      in_key:        1'b1,
      key_matched:   1'b0,
      key_leading:   1'b1,
      value_leading: 1'b0,
      key_length:    4'd0,
      prefix_ok:     1'b1,
      halted:        1'b1
   };

   localparam logic [15:0][7:0] KEY_NAME = {
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h44, 8'h49, 8'h4e, 8'h4f, 8'h49, 8'h53, 8'h53, 8'h45, 8'h53, 8'h48
   };

endpackage
`default_nettype wire

// ----- sv/cookie_session_id_extractor.sv -----
// top level: cookie header scanner that streams the session id value
`default_nettype none
// Takes one Cookie header byte per beat and gives exactly one result beat per
// input beat: a session value byte, a commit mark at ';' or NUL after a
// matching key, a malformed-start mark, or nothing. One beat per cycle is
// sustained while rsp_stall is low; an accepted beat passes through the input
// register, then the parse step into the result register. The parse state is
// updated as a beat moves into the result register, so the state loop, a
// single register, sets the rate. A result held by rsp_stall stalls the input
// only once the input register is also full.
module cookie_session_id_extractor (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_header_byte,
   input  logic       req_header_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_value_byte,
   output logic [1:0] rsp_kind
);

   logic                     s1_valid_ff, s1_valid_in;
   logic [7:0]               s1_byte_ff;
   logic                     s1_start_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_byte_ff;
   csx_pkg::kind_type        rsp_kind_ff;
   csx_pkg::parse_state_type state_ff, state_in;
   csx_pkg::parse_state_type state_next;
   csx_pkg::kind_type        step_kind;
   logic [7:0]               step_byte;
   logic                     out_ready;
   logic                     advance;

   csx_parser u_parser (
      .state        (state_ff),
      .header_byte  (s1_byte_ff),
      .header_start (s1_start_ff),
      .state_next   (state_next),
      .kind         (step_kind),
      .value_byte   (step_byte)
   );

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign advance      = s1_valid_ff && out_ready;
   assign req_stall    = s1_valid_ff && !out_ready;
   assign s1_valid_in  = req_stall ? s1_valid_ff : req_valid;
   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   assign state_in     = advance ? state_next : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= csx_pkg::STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_byte_ff  <= req_header_byte;
         s1_start_ff <= req_header_start;
      end
      if (advance) begin
         rsp_byte_ff <= step_byte;
         rsp_kind_ff <= step_kind;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value_byte = rsp_byte_ff;
   assign rsp_kind       = rsp_kind_ff;

endmodule
`default_nettype wire

// ----- sv/csx_parser.sv -----
// per-beat parse step: next state and result from the current state and one header byte
`default_nettype none
module csx_parser (
   input  csx_pkg::parse_state_type state,
   input  logic [7:0]               header_byte,
   input  logic                     header_start,
   output csx_pkg::parse_state_type state_next,
   output csx_pkg::kind_type        kind,
   output logic [7:0]               value_byte
);

   always_comb begin
      csx_pkg::parse_state_type cur;
      logic                     bad_start;
      logic                     name_hit;
      cur        = state;
      bad_start  = 1'b0;
      kind       = csx_pkg::KIND_NONE;
      value_byte = 8'd0;
      name_hit   = (cur.key_length < 4'(csx_pkg::KEY_LENGTH)) &&
                   (header_byte == csx_pkg::KEY_NAME[cur.key_length]);

      if (header_start) begin
         cur = csx_pkg::NEW_PAIR;
         if (header_byte == csx_pkg::CHAR_NUL || header_byte == csx_pkg::CHAR_EQ ||
             header_byte == csx_pkg::CHAR_SEMI) begin
            bad_start  = 1'b1;
            cur.halted = 1'b1;
            kind       = csx_pkg::KIND_BAD;
         end
         name_hit = (header_byte == csx_pkg::KEY_NAME[0]);
      end

      if (!bad_start && !cur.halted) begin
         if (header_byte == csx_pkg::CHAR_NUL) begin
            if (!cur.in_key && cur.key_matched) kind = csx_pkg::KIND_COMMIT;
            cur.halted = 1'b1;
         end else if (header_byte == csx_pkg::CHAR_SEMI) begin
            if (!cur.in_key && cur.key_matched) kind = csx_pkg::KIND_COMMIT;
            cur = csx_pkg::NEW_PAIR;
         end else if (cur.in_key) begin
            if (header_byte == csx_pkg::CHAR_EQ) begin
               cur.key_matched   = cur.prefix_ok;
               cur.in_key        = 1'b0;
               cur.value_leading = 1'b1;
            end else if (!(header_byte == csx_pkg::CHAR_SPACE && cur.key_leading)) begin
               cur.key_leading = 1'b0;
               if (!name_hit) cur.prefix_ok = 1'b0;
               if (cur.key_length != 4'd15) cur.key_length = cur.key_length + 4'd1;
            end
         end else begin
            if (!(header_byte == csx_pkg::CHAR_SPACE && cur.value_leading)) begin
               cur.value_leading = 1'b0;
               if (cur.key_matched) begin
                  kind       = csx_pkg::KIND_BYTE;
                  value_byte = header_byte;
               end
            end
         end
      end

      state_next = cur;
   end

endmodule
`default_nettype wire

// ----- sv/csx_checker.sv -----
// port-level checker for the cookie session id extractor, with its bind
`default_nettype none
module csx_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_value_byte,
   input logic [1:0] rsp_kind
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value_byte) && $stable(rsp_kind))
      else $error("stalled result beat changed");

   // only value bytes carry data
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != csx_pkg::KIND_BYTE) |-> rsp_value_byte == 8'd0)
      else $error("data on a non-byte result");

   // a value byte is never a terminator
   a_byte_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == csx_pkg::KIND_BYTE) |->
         rsp_value_byte != csx_pkg::CHAR_NUL && rsp_value_byte != csx_pkg::CHAR_SEMI)
      else $error("terminator streamed as value byte");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind cookie_session_id_extractor csx_checker u_csx_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_value_byte (rsp_value_byte),
   .rsp_kind       (rsp_kind)
);
`default_nettype wire

// ----- dv/tb.sv -----
// testbench: streams cookie header bytes into the session id extractor and checks every result beat
module tb;

   localparam int ITEMS = 1450;
   localparam logic [79:0] SESSION_KEY = "HSESSIONID";

   typedef struct packed {
      logic [7:0]        data;
      logic              first;
      logic              typed;
      csx_pkg::kind_type kind;
      logic [7:0]        value;
   } step_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_header_byte;
   logic       req_header_start;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_value_byte;
   logic [1:0] rsp_kind;

   // scan state
   logic       scan_in_key;
   logic       scan_matched;
   logic       scan_key_lead;
   logic       scan_value_lead;
   logic [3:0] scan_key_len;
   logic       scan_prefix_ok;
   logic       scan_halted;

   csx_pkg::kind_type pending_kind [$];
   logic [7:0]        pending_value [$];
   logic [7:0]        script_byte [$];
   logic              script_start [$];
   logic              script_opening;
   step_row_type      rows [$];

   int                errors = 0;
   int                live_items = 0;
   int                burst_left = 0;
   int                hold_offs = 0;
   int                byte_beats = 0;
   int                commit_beats = 0;
   int                bad_beats = 0;
   csx_pkg::kind_type want_kind;
   logic [7:0]        want_value;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cookie_session_id_extractor uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_header_byte  (req_header_byte),
      .req_header_start (req_header_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_kind         (rsp_kind)
   );

   initial begin
      #3000000;
      $display("FAILURE");
      $finish;
   end

   // receiver: stretches of differing stall density, now and then a long hold-off
   initial begin : receiver
      int stretch, span, pct;
      rsp_stall = 1'b0;
      stretch = 0;
      forever begin
         stretch++;
         if (stretch % 40 == 3) begin
            pct = 100;
            span = 60;
            hold_offs++;
         end else begin
            case ($urandom_range(0, 3))
               0: pct = 0;
               1: pct = 25;
               2: pct = 60;
               default: pct = 90;
            endcase
            span = $urandom_range(5, 40);
         end
         repeat (span) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         case (rsp_kind)
            csx_pkg::KIND_BYTE: byte_beats++;
            csx_pkg::KIND_COMMIT: commit_beats++;
            csx_pkg::KIND_BAD: bad_beats++;
            default: ;
         endcase
         if (pending_kind.size() == 0) begin
            $display("%0t: result beat with none expected: kind %0d value %02h",
                     $time, rsp_kind, rsp_value_byte);
            errors++;
         end else begin
            want_kind = pending_kind.pop_front();
            want_value = pending_value.pop_front();
            if (rsp_kind !== want_kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want_kind, rsp_kind);
               errors++;
            end
            if (rsp_value_byte !== want_value) begin
               $display("%0t: value byte expected %02h actual %02h",
                        $time, want_value, rsp_value_byte);
               errors++;
            end
         end
      end
   end

   function automatic logic [7:0] key_char(input int unsigned i);
      return SESSION_KEY[8 * (csx_pkg::KEY_LENGTH - 1 - i) +: 8];
   endfunction

   task automatic restart_pair;
      scan_in_key = 1'b1;
      scan_matched = 1'b0;
      scan_key_lead = 1'b1;
      scan_value_lead = 1'b0;
      scan_key_len = 4'd0;
      scan_prefix_ok = 1'b1;
   endtask

   task automatic scan_byte(input logic [7:0] b, input logic s,
                            output csx_pkg::kind_type k, output logic [7:0] v);
      k = csx_pkg::KIND_NONE;
      v = 8'h00;
      if (s) begin
         restart_pair();
         scan_halted = (b == csx_pkg::CHAR_NUL || b == csx_pkg::CHAR_EQ ||
                        b == csx_pkg::CHAR_SEMI);
         if (scan_halted)
            k = csx_pkg::KIND_BAD;
      end
      if (!scan_halted) begin
         if (b == csx_pkg::CHAR_NUL) begin
            if (!scan_in_key && scan_matched)
               k = csx_pkg::KIND_COMMIT;
            scan_halted = 1'b1;
         end else if (b == csx_pkg::CHAR_SEMI) begin
            if (!scan_in_key && scan_matched)
               k = csx_pkg::KIND_COMMIT;
            restart_pair();
         end else if (scan_in_key) begin
            if (b == csx_pkg::CHAR_EQ) begin
               scan_matched = scan_prefix_ok;
               scan_in_key = 1'b0;
               scan_value_lead = 1'b1;
            end else if (!(b == csx_pkg::CHAR_SPACE && scan_key_lead)) begin
               scan_key_lead = 1'b0;
               if (scan_key_len >= csx_pkg::KEY_LENGTH || b != key_char(scan_key_len))
                  scan_prefix_ok = 1'b0;
               if (scan_key_len != 4'd15)
                  scan_key_len++;
            end
         end else if (!(b == csx_pkg::CHAR_SPACE && scan_value_lead)) begin
            scan_value_lead = 1'b0;
            if (scan_matched) begin
               k = csx_pkg::KIND_BYTE;
               v = b;
            end
         end
      end
   endtask

   task automatic offer(input logic [7:0] b, input logic s, input logic typed,
                        input csx_pkg::kind_type k, input logic [7:0] v);
      csx_pkg::kind_type pk;
      logic [7:0]        pv;
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_header_byte <= b;
      req_header_start <= s;
      do @(posedge clock); while (req_stall !== 1'b0);
      burst_left--;
      if (s || !scan_halted)
         live_items++;
      scan_byte(b, s, pk, pv);
      pending_kind.push_back(typed ? k : pk);
      pending_value.push_back(typed ? v : pv);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_kind.size() != 0);
   endtask

   task automatic script_add(input logic [7:0] b);
      script_byte.push_back(b);
      script_start.push_back(script_opening);
      script_opening = 1'b0;
   endtask

   task automatic compose_header;
      int pairs, style, n, i, j;
      logic [7:0] c;
      script_opening = 1'b1;
      if ($urandom_range(0, 4) == 0) begin
         // noise, malformed starts among it
         n = $urandom_range(1, 6);
         for (i = 0; i < n; i++) begin
            script_byte.push_back(8'($urandom_range(0, 255)));
            script_start.push_back($urandom_range(0, 2) == 0);
         end
      end else begin
         pairs = $urandom_range(1, 4);
         for (i = 0; i < pairs; i++) begin
            repeat ($urandom_range(0, 2)) script_add(csx_pkg::CHAR_SPACE);
            style = $urandom_range(0, 9);
            n = (style < 4 || style == 5) ? csx_pkg::KEY_LENGTH :
                $urandom_range(0, csx_pkg::KEY_LENGTH - 1);
            if (style < 7)
               for (j = 0; j < n; j++)
                  script_add(key_char(j));
            case (style)
               5: repeat ($urandom_range(1, 8)) script_add(8'($urandom_range(8'h41, 8'h5a)));
               6: script_add(8'(8'h61 + $urandom_range(0, 25)));
               7, 8: repeat ($urandom_range(1, 6)) begin
                  c = 8'($urandom_range(8'h21, 8'h7e));
                  if (c == csx_pkg::CHAR_EQ || c == csx_pkg::CHAR_SEMI)
                     c = 8'h2d;
                  script_add(c);
               end
               default: ;
            endcase
            if (style != 8)
               script_add(csx_pkg::CHAR_EQ);
            repeat ($urandom_range(0, 2)) script_add(csx_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(1, 255));
               if (c == csx_pkg::CHAR_SEMI)
                  c = csx_pkg::CHAR_EQ;
               script_add(c);
            end
            if (i < pairs - 1) begin
               script_add(csx_pkg::CHAR_SEMI);
            end else begin
               case ($urandom_range(0, 3))
                  0: ;
                  1: script_add(csx_pkg::CHAR_SEMI);
                  default: begin
                     script_add(csx_pkg::CHAR_NUL);
                     repeat ($urandom_range(0, 2)) script_add(8'($urandom_range(0, 255)));
                  end
               endcase
            end
         end
      end
   endtask

   initial begin : stimulus
      step_row_type row;
      logic         paused;
      reset = 1'b1;
      req_valid = 1'b0;
      req_header_byte = 8'h00;
      req_header_start = 1'b0;
      paused = 1'b0;
      restart_pair();
      scan_halted = 1'b1;

      //   byte                 start typed kind                  value
      rows.push_back({8'h78,               1'b0, 1'b1, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_NUL,   1'b1, 1'b1, csx_pkg::KIND_BAD,    8'h00});
      rows.push_back({8'h61,               1'b0, 1'b1, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_EQ,    1'b1, 1'b1, csx_pkg::KIND_BAD,    8'h00});
      rows.push_back({csx_pkg::CHAR_SEMI,  1'b1, 1'b1, csx_pkg::KIND_BAD,    8'h00});
      rows.push_back({csx_pkg::CHAR_SPACE, 1'b1, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'h48,               1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_EQ,    1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_SPACE, 1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'hff,               1'b0, 1'b1, csx_pkg::KIND_BYTE,   8'hff});
      rows.push_back({csx_pkg::CHAR_EQ,    1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_SEMI,  1'b0, 1'b1, csx_pkg::KIND_COMMIT, 8'h00});
      rows.push_back({csx_pkg::CHAR_EQ,    1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_SEMI,  1'b0, 1'b1, csx_pkg::KIND_COMMIT, 8'h00});
      rows.push_back({8'h58,               1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_SEMI,  1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'h51,               1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_NUL,   1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'h5a,               1'b0, 1'b1, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'h48,               1'b1, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({csx_pkg::CHAR_EQ,    1'b0, 1'b0, csx_pkg::KIND_NONE,   8'h00});
      rows.push_back({8'h80,               1'b0, 1'b1, csx_pkg::KIND_BYTE,   8'h80});
      rows.push_back({csx_pkg::CHAR_NUL,   1'b0, 1'b1, csx_pkg::KIND_COMMIT, 8'h00});
      rows.push_back({8'h7f,               1'b0, 1'b1, csx_pkg::KIND_NONE,   8'h00});

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         row = rows[i];
         offer(row.data, row.first, row.typed, row.kind, row.value);
      end
      drain();

      while (live_items < ITEMS) begin
         compose_header();
         while (script_byte.size() != 0)
            offer(script_byte.pop_front(), script_start.pop_front(), 1'b0,
                  csx_pkg::KIND_NONE, 8'h00);
         if (!paused && live_items >= ITEMS / 2) begin
            drain();
            paused = 1'b1;
         end
      end
      drain();
      repeat (8) @(posedge clock);

      $display("scanned %0d live header beats through %0d receiver hold-offs", live_items,
               hold_offs);
      $display("results seen: %0d value bytes, %0d commits, %0d malformed starts",
               byte_beats, commit_beats, bad_beats);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
